>>> hw/rtl/lobm_pkg.sv
// Shared types, codes and constants of the limit order book matcher.
// No dependencies; imported by every module of the block.
`default_nettype none
package lobm_pkg;

    localparam int MAX_ORDERS_DEF  = 64;
    localparam int NUM_SYMBOLS_DEF = 8;
    localparam int MAX_TRADES      = 63;
    localparam int TRADE_CNT_W     = 6;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] CMD_NEW    = 2'd0;
    localparam logic [1:0] CMD_MODIFY = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic [1:0] SIDE_BUY  = 2'd1;
    localparam logic [1:0] SIDE_SELL = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_CREATED  = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [3:0] KNOWN_SYMBOLS_RESET = 4'd8;

    typedef enum logic [1:0] {
        OP_NEW,
        OP_MODIFY,
        OP_CANCEL,
        OP_REJECT
    } t_op;

    // classified command as it sits in the queue
    typedef struct packed {
        t_op         op;
        logic [31:0] order_id;
        logic [7:0]  symbol;
        logic        sell;
        logic [15:0] price;
        logic [15:0] quantity;
    } t_item;

    // one resting order in the table
    typedef struct packed {
        logic [31:0] order_id;
        logic [15:0] price;
        logic [15:0] remaining;
        logic        sell;
        logic [7:0]  symbol;
        logic [31:0] sequence_no;
    } t_entry;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [31:0] buy_order_id;
        logic [31:0] sell_order_id;
        logic [15:0] buy_price;
        logic [15:0] sell_price;
        logic [15:0] fill_quantity;
        logic [2:0]  trade_symbol;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_INSERT,
        S_MSCAN,
        S_MEVAL,
        S_WRB,
        S_WRA,
        S_STATUS
    } t_state;

endpackage
`default_nettype wire

>>> hw/rtl/lobm_front.sv
// Front end: command intake, field checks and classification.
// Depends on lobm_pkg.
`default_nettype none
module lobm_front
    import lobm_pkg::*;
#(
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        i_accept,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_order_id,
    input  wire logic [7:0]  i_symbol,
    input  wire logic [1:0]  i_side_code,
    input  wire logic [15:0] i_price,
    input  wire logic [15:0] i_quantity,
    output t_item            o_item,
    output logic             o_push
);

    logic [3:0] r_known;
    logic [8:0] sym_limit;
    logic       bad_fields;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= KNOWN_SYMBOLS_RESET;
        end else if (i_cfg_we) begin
            r_known <= i_cfg_wdata;
        end
    end

    always_comb begin
        sym_limit  = ({5'd0, r_known} > 9'(NUM_SYMBOLS)) ? 9'(NUM_SYMBOLS) : {5'd0, r_known};
        bad_fields = (i_side_code != SIDE_BUY && i_side_code != SIDE_SELL)
                   || ({1'b0, i_symbol} >= sym_limit)
                   || (i_price == 16'd0) || (i_quantity == 16'd0);
        o_item.order_id = i_order_id;
        o_item.symbol   = i_symbol;
        o_item.sell     = (i_side_code == SIDE_SELL);
        o_item.price    = i_price;
        o_item.quantity = i_quantity;
        // cancel ignores every field but the id
        if (i_command == CMD_CANCEL) begin
            o_item.op = OP_CANCEL;
        end else if (bad_fields || (i_command != CMD_NEW && i_command != CMD_MODIFY)) begin
            o_item.op = OP_REJECT;
        end else if (i_command == CMD_NEW) begin
            o_item.op = OP_NEW;
        end else begin
            o_item.op = OP_MODIFY;
        end
        o_push = i_accept;
    end

endmodule
`default_nettype wire

>>> hw/rtl/lobm_queue.sv
// Short queue of classified commands between front and back end.
// Depends on lobm_pkg.
`default_nettype none
module lobm_queue
    import lobm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_item      i_item,
    input  wire logic  i_pop,
    output t_item      o_item,
    output logic       o_valid,
    output logic       o_full
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item          r_slots [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [PW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_slots[r_wr] <= i_item;
                r_wr          <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    assign o_item  = r_slots[r_rd];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (PW+1)'(QUEUE_DEPTH));

endmodule
`default_nettype wire

>>> hw/rtl/lobm_back.sv
// Back end: order table, id lookup, insertion and price-time matching.
// Depends on lobm_pkg.
`default_nettype none
module lobm_back
    import lobm_pkg::*;
#(
    parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_item     i_item,
    input  wire logic i_item_valid,
    output logic      o_pop,
    output t_result   o_result,
    output logic      o_result_valid
);

    localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int CW = $clog2(MAX_ORDERS + 1);

    t_state r_state, n_state;

    t_entry                  r_mem [MAX_ORDERS];
    logic [MAX_ORDERS-1:0]   r_valid;
    t_entry                  r_rd_data;
    logic                    r_rd_pend;
    logic [AW-1:0]           r_rd_idx;
    logic [CW-1:0]           r_addr;

    t_item                   r_cmd;
    logic [1:0]              r_status;
    logic                    r_found;
    logic [AW-1:0]           r_found_idx;
    logic [7:0]              r_found_sym;
    logic                    r_free_ok;
    logic [AW-1:0]           r_free_idx;
    logic [AW-1:0]           r_slot;
    logic [31:0]             r_arrival;
    logic [TRADE_CNT_W-1:0]  r_trades;

    logic                    r_b_ok, r_a_ok;
    logic [AW-1:0]           r_b_idx, r_a_idx;
    logic [31:0]             r_b_id, r_a_id;
    logic [15:0]             r_b_price, r_a_price;
    logic [15:0]             r_b_rem, r_a_rem;
    logic [31:0]             r_b_seq, r_a_seq;

    t_result                 r_res;
    logic                    r_res_valid;

    logic          scan_done;
    logic          rd_live;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic          go_insert;
    logic          crossing;
    logic [15:0]   fill_q;
    logic [31:0]   age_e, age_b, age_a;
    logic          take_b, take_a;

    always_comb begin
        scan_done = (r_addr == CW'(MAX_ORDERS)) && !r_rd_pend;
        rd_live   = r_rd_pend && r_valid[r_rd_idx];
        go_insert = (r_cmd.op == OP_NEW) ? (!r_found && r_free_ok)
                  : (r_cmd.op == OP_MODIFY && r_found && r_found_sym == r_cmd.symbol);
        crossing  = r_b_ok && r_a_ok && (r_b_price >= r_a_price)
                  && (r_trades != TRADE_CNT_W'(MAX_TRADES));
        fill_q    = (r_b_rem < r_a_rem) ? r_b_rem : r_a_rem;

        // older means larger distance back from the arrival counter
        age_e  = r_arrival - r_rd_data.sequence_no;
        age_b  = r_arrival - r_b_seq;
        age_a  = r_arrival - r_a_seq;
        take_b = rd_live && !r_rd_data.sell && r_rd_data.symbol == r_cmd.symbol
               && (!r_b_ok || ((r_rd_data.price != r_b_price) ? (r_rd_data.price > r_b_price)
                                                                 : (age_e > age_b)));
        take_a = rd_live && r_rd_data.sell && r_rd_data.symbol == r_cmd.symbol
               && (!r_a_ok || ((r_rd_data.price != r_a_price) ? (r_rd_data.price < r_a_price)
                                                                 : (age_e > age_a)));

        n_state   = r_state;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = '{order_id: r_cmd.order_id, price: r_cmd.price,
                      remaining: r_cmd.quantity, sell: r_cmd.sell,
                      symbol: r_cmd.symbol, sequence_no: r_arrival};
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_state = (i_item.op == OP_REJECT) ? S_STATUS : S_FIND;
                end
            end
            S_FIND: begin
                if (scan_done) begin
                    n_state = go_insert ? S_INSERT : S_STATUS;
                end
            end
            S_INSERT: begin
                mem_we  = 1'b1;
                n_state = S_MSCAN;
            end
            S_MSCAN: begin
                if (scan_done) begin
                    n_state = S_MEVAL;
                end
            end
            S_MEVAL: begin
                n_state = crossing ? S_WRB : S_STATUS;
            end
            S_WRB: begin
                mem_we    = 1'b1;
                mem_waddr = r_b_idx;
                mem_wdata = '{order_id: r_b_id, price: r_b_price, remaining: r_b_rem,
                              sell: 1'b0, symbol: r_cmd.symbol, sequence_no: r_b_seq};
                n_state   = S_WRA;
            end
            S_WRA: begin
                mem_we    = 1'b1;
                mem_waddr = r_a_idx;
                mem_wdata = '{order_id: r_a_id, price: r_a_price, remaining: r_a_rem,
                              sell: 1'b1, symbol: r_cmd.symbol, sequence_no: r_a_seq};
                n_state   = S_MSCAN;
            end
            S_STATUS: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // table storage: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_arrival   <= '0;
            r_res_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_addr      <= '0;
        end else begin
            r_res_valid <= 1'b0;

            // sweep address generator shared by both scans
            if (r_state == S_FIND || r_state == S_MSCAN) begin
                if (r_addr != CW'(MAX_ORDERS)) begin
                    r_rd_pend <= 1'b1;
                    r_rd_idx  <= r_addr[AW-1:0];
                    r_addr    <= r_addr + 1'b1;
                end else begin
                    r_rd_pend <= 1'b0;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    r_addr    <= '0;
                    r_rd_pend <= 1'b0;
                    r_found   <= 1'b0;
                    r_free_ok <= 1'b0;
                    if (i_item_valid) begin
                        r_cmd    <= i_item;
                        r_status <= STATUS_REJECTED;
                    end
                end
                S_FIND: begin
                    if (rd_live && r_rd_data.order_id == r_cmd.order_id) begin
                        r_found     <= 1'b1;
                        r_found_idx <= r_rd_idx;
                        r_found_sym <= r_rd_data.symbol;
                    end
                    if (r_rd_pend && !r_valid[r_rd_idx] && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_rd_idx;
                    end
                    if (scan_done) begin
                        unique case (r_cmd.op)
                            OP_CANCEL: begin
                                if (r_found) begin
                                    r_valid[r_found_idx] <= 1'b0;
                                end
                                r_status <= STATUS_OK;
                            end
                            OP_NEW: begin
                                r_slot   <= r_free_idx;
                                r_status <= r_found ? STATUS_REJECTED
                                          : (r_free_ok ? STATUS_CREATED : STATUS_FULL);
                            end
                            OP_MODIFY: begin
                                r_slot   <= r_found_idx;
                                r_status <= STATUS_OK;
                            end
                            OP_REJECT: begin
                                r_status <= STATUS_REJECTED;
                            end
                            default: begin
                                r_status <= STATUS_REJECTED;
                            end
                        endcase
                    end
                end
                S_INSERT: begin
                    r_valid[r_slot] <= 1'b1;
                    r_arrival       <= r_arrival + 32'd1;
                    r_trades        <= '0;
                    r_addr          <= '0;
                    r_rd_pend       <= 1'b0;
                    r_b_ok          <= 1'b0;
                    r_a_ok          <= 1'b0;
                end
                S_MSCAN: begin
                    if (take_b) begin
                        r_b_ok    <= 1'b1;
                        r_b_idx   <= r_rd_idx;
                        r_b_id    <= r_rd_data.order_id;
                        r_b_price <= r_rd_data.price;
                        r_b_rem   <= r_rd_data.remaining;
                        r_b_seq   <= r_rd_data.sequence_no;
                    end
                    if (take_a) begin
                        r_a_ok    <= 1'b1;
                        r_a_idx   <= r_rd_idx;
                        r_a_id    <= r_rd_data.order_id;
                        r_a_price <= r_rd_data.price;
                        r_a_rem   <= r_rd_data.remaining;
                        r_a_seq   <= r_rd_data.sequence_no;
                    end
                end
                S_MEVAL: begin
                    if (crossing) begin
                        r_b_rem     <= r_b_rem - fill_q;
                        r_a_rem     <= r_a_rem - fill_q;
                        r_trades    <= r_trades + 1'b1;
                        r_res_valid <= 1'b1;
                        r_res       <= '{kind: KIND_TRADE, status: STATUS_OK,
                                         buy_order_id: r_b_id, sell_order_id: r_a_id,
                                         buy_price: r_b_price, sell_price: r_a_price,
                                         fill_quantity: fill_q,
                                         trade_symbol: r_cmd.symbol[2:0], last: 1'b0};
                    end
                end
                S_WRB: begin
                    if (r_b_rem == 16'd0) begin
                        r_valid[r_b_idx] <= 1'b0;
                    end
                end
                S_WRA: begin
                    if (r_a_rem == 16'd0) begin
                        r_valid[r_a_idx] <= 1'b0;
                    end
                    r_addr    <= '0;
                    r_rd_pend <= 1'b0;
                    r_b_ok    <= 1'b0;
                    r_a_ok    <= 1'b0;
                end
                S_STATUS: begin
                    r_res_valid <= 1'b1;
                    r_res       <= '{kind: KIND_STATUS, status: r_status,
                                     buy_order_id: 32'd0, sell_order_id: 32'd0,
                                     buy_price: 16'd0, sell_price: 16'd0,
                                     fill_quantity: 16'd0, trade_symbol: 3'd0, last: 1'b1};
                end
                default: begin
                    r_rd_pend <= 1'b0;
                end
            endcase
        end
    end

    assign o_result       = r_res;
    assign o_result_valid = r_res_valid;

endmodule
`default_nettype wire

>>> hw/rtl/limit_order_book_matcher_core.sv
// Limit order book matcher, top level: front end, command queue, back end.
// Depends on lobm_pkg, lobm_front, lobm_queue, lobm_back.
`default_nettype none
// A command is taken when start is high and busy low; busy rises only when the
// two-deep command queue is full. Each command yields zero or more trade beats
// and then one status beat with o_last set; every beat is on the outputs for a
// single cycle under o_result_valid and cannot be held off. Work per command is
// set by sweeps of the order table, one entry a cycle through its single read
// port: a rejected command skips the sweeps, a cancel or failed lookup takes one
// sweep, and an insert takes a lookup and a match sweep plus one more match sweep
// for every fill. The valid bits reset at once; no clearing pass is needed.
module limit_order_book_matcher_core
    import lobm_pkg::*;
#(
    parameter int MAX_ORDERS  = MAX_ORDERS_DEF,
    parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_order_id,
    input  wire logic [7:0]  i_symbol,
    input  wire logic [1:0]  i_side_code,
    input  wire logic [15:0] i_price,
    input  wire logic [15:0] i_quantity,
    output logic             o_result_valid,
    output logic             o_kind,
    output logic [1:0]       o_status,
    output logic [31:0]      o_buy_order_id,
    output logic [31:0]      o_sell_order_id,
    output logic [15:0]      o_buy_price,
    output logic [15:0]      o_sell_price,
    output logic [15:0]      o_fill_quantity,
    output logic [2:0]       o_trade_symbol,
    output logic             o_last
);

    t_item   front_item;
    t_item   queue_item;
    logic    push, pop, queue_valid, queue_full;
    t_result result;

    lobm_front #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (start && !queue_full),
        .i_command   (i_command),
        .i_order_id  (i_order_id),
        .i_symbol    (i_symbol),
        .i_side_code (i_side_code),
        .i_price     (i_price),
        .i_quantity  (i_quantity),
        .o_item      (front_item),
        .o_push      (push)
    );

    lobm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_valid (queue_valid),
        .o_full  (queue_full)
    );

    lobm_back #(.MAX_ORDERS(MAX_ORDERS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (queue_item),
        .i_item_valid   (queue_valid),
        .o_pop          (pop),
        .o_result       (result),
        .o_result_valid (o_result_valid)
    );

    assign busy            = queue_full;
    assign o_kind          = result.kind;
    assign o_status        = result.status;
    assign o_buy_order_id  = result.buy_order_id;
    assign o_sell_order_id = result.sell_order_id;
    assign o_buy_price     = result.buy_price;
    assign o_sell_price    = result.sell_price;
    assign o_fill_quantity = result.fill_quantity;
    assign o_trade_symbol  = result.trade_symbol;
    assign o_last          = result.last;

    a_last_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((o_kind == KIND_STATUS) == o_last))
        else $error("last flag does not match beat kind");

    a_trade_crosses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_kind == KIND_TRADE) |->
            (o_buy_price >= o_sell_price && o_fill_quantity != 16'd0))
        else $error("trade without crossing prices or with empty fill");

    a_trade_then_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_kind == KIND_TRADE) |=> !o_result_valid)
        else $error("beat directly after a trade");

endmodule
`default_nettype wire

>>> test/limit_order_book_matcher_core_tb.sv
// Self-checking bench for limit_order_book_matcher_core: directed and random order commands,
// with a price-time priority book model predicting every trade and status beat.
// Depends on lobm_pkg and the core RTL only.
`timescale 1ns / 100ps
module limit_order_book_matcher_core_tb
    import lobm_pkg::*;
();

    localparam int ORDERS   = MAX_ORDERS_DEF;
    localparam int SYMBOLS  = NUM_SYMBOLS_DEF;
    localparam int LIMIT_CYCLES = 4_000_000;

    typedef struct {
        logic [1:0]  command;
        logic [31:0] order_id;
        logic [7:0]  symbol;
        logic [1:0]  side_code;
        logic [15:0] price;
        logic [15:0] quantity;
    } t_order_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_wdata = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = '0;
    logic [31:0] i_order_id = '0;
    logic [7:0]  i_symbol = '0;
    logic [1:0]  i_side_code = '0;
    logic [15:0] i_price = '0;
    logic [15:0] i_quantity = '0;
    logic        o_result_valid;
    logic        o_kind;
    logic [1:0]  o_status;
    logic [31:0] o_buy_order_id;
    logic [31:0] o_sell_order_id;
    logic [15:0] o_buy_price;
    logic [15:0] o_sell_price;
    logic [15:0] o_fill_quantity;
    logic [2:0]  o_trade_symbol;
    logic        o_last;

    limit_order_book_matcher_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy),
        .i_command(i_command), .i_order_id(i_order_id), .i_symbol(i_symbol),
        .i_side_code(i_side_code), .i_price(i_price), .i_quantity(i_quantity),
        .o_result_valid(o_result_valid), .o_kind(o_kind), .o_status(o_status),
        .o_buy_order_id(o_buy_order_id), .o_sell_order_id(o_sell_order_id),
        .o_buy_price(o_buy_price), .o_sell_price(o_sell_price),
        .o_fill_quantity(o_fill_quantity), .o_trade_symbol(o_trade_symbol),
        .o_last(o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // book model
    bit          bk_valid [ORDERS];
    logic [31:0] bk_id    [ORDERS];
    logic [15:0] bk_price [ORDERS];
    logic [15:0] bk_rem   [ORDERS];
    bit          bk_sell  [ORDERS];
    logic [7:0]  bk_sym   [ORDERS];
    logic [31:0] bk_seq   [ORDERS];
    logic [31:0] arrivals = '0;
    logic [3:0]  known_syms = KNOWN_SYMBOLS_RESET;

    t_order_cmd  order_q [$];
    t_result     beats_due [$];
    int          errors = 0;
    int          accepted = 0;
    int          cycles = 0;

    function automatic int locate(logic [31:0] id);
        for (int i = 0; i < ORDERS; i++)
            if (bk_valid[i] && bk_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < ORDERS; i++)
            if (!bk_valid[i]) return i;
        return -1;
    endfunction

    function automatic int best_of(logic [7:0] sym, bit sell);
        int b;
        b = -1;
        for (int i = 0; i < ORDERS; i++) begin
            if (!bk_valid[i] || bk_sym[i] != sym || bk_sell[i] != sell) continue;
            if (b < 0) begin
                b = i;
            end else if (bk_price[i] != bk_price[b]) begin
                if (sell ? (bk_price[i] < bk_price[b]) : (bk_price[i] > bk_price[b])) b = i;
            end else if (32'(arrivals - bk_seq[i]) > 32'(arrivals - bk_seq[b])) begin
                b = i;
            end
        end
        return b;
    endfunction

    function automatic void place(int slot, t_order_cmd c);
        bk_valid[slot] = 1'b1;
        bk_id[slot]    = c.order_id;
        bk_sym[slot]   = c.symbol;
        bk_sell[slot]  = (c.side_code == SIDE_SELL);
        bk_price[slot] = c.price;
        bk_rem[slot]   = c.quantity;
        bk_seq[slot]   = arrivals;
        arrivals++;
    endfunction

    function automatic void cross_book(logic [7:0] sym);
        int b, a, n;
        logic [15:0] q;
        t_result r;
        n = 0;
        while (n < MAX_TRADES) begin
            b = best_of(sym, 1'b0);
            a = best_of(sym, 1'b1);
            if (b < 0 || a < 0 || bk_price[b] < bk_price[a]) break;
            q = (bk_rem[b] < bk_rem[a]) ? bk_rem[b] : bk_rem[a];
            bk_rem[b] -= q;
            bk_rem[a] -= q;
            r = '0;
            r.kind = KIND_TRADE;
            r.status = STATUS_OK;
            r.buy_order_id = bk_id[b];
            r.sell_order_id = bk_id[a];
            r.buy_price = bk_price[b];
            r.sell_price = bk_price[a];
            r.fill_quantity = q;
            r.trade_symbol = sym[2:0];
            beats_due = {beats_due, r};
            n++;
            if (bk_rem[b] == 0) bk_valid[b] = 1'b0;
            if (bk_rem[a] == 0) bk_valid[a] = 1'b0;
        end
    endfunction

    function automatic void apply_order(t_order_cmd c);
        int slot, lim;
        logic [1:0] st;
        t_result r;
        lim = (known_syms > SYMBOLS) ? SYMBOLS : known_syms;
        if (c.command == CMD_CANCEL) begin
            slot = locate(c.order_id);
            if (slot >= 0) bk_valid[slot] = 1'b0;
            st = STATUS_OK;
        end else if (c.command == 2'd3 || (c.side_code != SIDE_BUY && c.side_code != SIDE_SELL)
                     || c.symbol >= lim || c.price == 0 || c.quantity == 0) begin
            st = STATUS_REJECTED;
        end else if (c.command == CMD_NEW) begin
            if (locate(c.order_id) >= 0) begin
                st = STATUS_REJECTED;
            end else begin
                slot = free_slot();
                if (slot < 0) begin
                    st = STATUS_FULL;
                end else begin
                    place(slot, c);
                    cross_book(c.symbol);
                    st = STATUS_CREATED;
                end
            end
        end else begin
            slot = locate(c.order_id);
            if (slot >= 0 && bk_sym[slot] == c.symbol) begin
                place(slot, c);
                cross_book(c.symbol);
            end
            st = STATUS_OK;
        end
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        r.last = 1'b1;
        beats_due = {beats_due, r};
    endfunction

    function automatic void add(logic [1:0] cmd, logic [31:0] id, logic [7:0] sym,
                                logic [1:0] side, logic [15:0] price, logic [15:0] qty);
        t_order_cmd c;
        c.command = cmd; c.order_id = id; c.symbol = sym;
        c.side_code = side; c.price = price; c.quantity = qty;
        order_q = {order_q, c};
    endfunction

    // mostly well-formed traffic on a small id pool so modifies and cancels hit
    function automatic void add_random(int sym_lim);
        logic [1:0] cmd;
        if ($urandom_range(99) < 22) begin
            add(2'($urandom), $urandom, 8'($urandom), 2'($urandom), 16'($urandom),
                16'($urandom));
        end else begin
            case ($urandom_range(3))
                0, 1:    cmd = CMD_NEW;
                2:       cmd = CMD_MODIFY;
                default: cmd = CMD_CANCEL;
            endcase
            add(cmd, $urandom_range(1, 24), 8'($urandom_range(sym_lim - 1)),
                $urandom_range(1) ? SIDE_SELL : SIDE_BUY,
                16'($urandom_range(95, 105)), 16'($urandom_range(1, 20)));
        end
    endfunction

    // driver: predicts at the edge where the command is taken
    always @(posedge i_clk) begin : drive
        bit held;
        bit quiet;
        t_order_cmd c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            held = start;
            quiet = (accepted >= 40 && accepted < 80);
            if (start && !busy) begin
                apply_order(c);
                accepted++;
                held = 1'b0;
            end
            if (!held) begin
                if (order_q.size() > 0 && (quiet || $urandom_range(99) >= 32)) begin
                    c = order_q[0];
                    order_q.delete(0);
                    i_command <= c.command;
                    i_order_id <= c.order_id;
                    i_symbol <= c.symbol;
                    i_side_code <= c.side_code;
                    i_price <= c.price;
                    i_quantity <= c.quantity;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h (beat at cycle %0d)", what, got, want,
                 cycles);
        errors++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result w;
        cycles++;
        if (i_rst_n && o_result_valid) begin
            if (beats_due.size() == 0) begin
                report_mismatch("unexpected beat, kind", o_kind, 'x);
            end else begin
                w = beats_due[0];
                beats_due.delete(0);
                check_field("kind", o_kind, w.kind);
                check_field("status", o_status, w.status);
                check_field("buy_order_id", o_buy_order_id, w.buy_order_id);
                check_field("sell_order_id", o_sell_order_id, w.sell_order_id);
                check_field("buy_price", o_buy_price, w.buy_price);
                check_field("sell_price", o_sell_price, w.sell_price);
                check_field("fill_quantity", o_fill_quantity, w.fill_quantity);
                check_field("trade_symbol", o_trade_symbol, w.trade_symbol);
                check_field("last", o_last, w.last);
            end
        end
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        do @(posedge i_clk); while (order_q.size() > 0 || start || beats_due.size() > 0);
        repeat (ORDERS + 10) @(posedge i_clk);
    endtask

    task automatic set_known(logic [3:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        known_syms = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < ORDERS; i++) bk_valid[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, rejects, modify and cancel cases, at reset symbol count
        add(CMD_NEW, 32'd0, 8'd7, SIDE_BUY, 16'hFFFF, 16'hFFFF);
        add(CMD_NEW, 32'hFFFF_FFFF, 8'd7, SIDE_SELL, 16'd1, 16'd1);
        add(CMD_NEW, 32'd5, 8'd0, SIDE_BUY, 16'd0, 16'd3);
        add(CMD_NEW, 32'd5, 8'd0, SIDE_BUY, 16'd10, 16'd0);
        add(CMD_NEW, 32'd5, 8'd0, 2'd0, 16'd10, 16'd3);
        add(CMD_NEW, 32'd5, 8'd0, 2'd3, 16'd10, 16'd3);
        add(CMD_NEW, 32'd5, 8'd8, SIDE_BUY, 16'd10, 16'd3);
        add(CMD_NEW, 32'd5, 8'hFF, SIDE_SELL, 16'd10, 16'd3);
        add(CMD_NEW, 32'd0, 8'd7, SIDE_BUY, 16'd10, 16'd3);
        add(2'd3, 32'd5, 8'd0, SIDE_BUY, 16'd10, 16'd3);
        add(CMD_MODIFY, 32'd77, 8'd0, SIDE_BUY, 16'd10, 16'd3);
        add(CMD_MODIFY, 32'd0, 8'd1, SIDE_BUY, 16'd10, 16'd3);
        add(CMD_MODIFY, 32'd0, 8'd7, SIDE_BUY, 16'd0, 16'd3);
        add(CMD_NEW, 32'd6, 8'd7, SIDE_BUY, 16'd50, 16'd4);
        add(CMD_MODIFY, 32'd0, 8'd7, SIDE_BUY, 16'd50, 16'd9);
        add(CMD_NEW, 32'd8, 8'd7, SIDE_SELL, 16'd40, 16'd6);
        add(CMD_NEW, 32'd9, 8'd7, SIDE_SELL, 16'd60, 16'd5);
        add(CMD_MODIFY, 32'd9, 8'd7, SIDE_SELL, 16'd45, 16'd20);
        add(CMD_CANCEL, 32'd1234, 8'd0, 2'd0, 16'd0, 16'd0);
        add(CMD_CANCEL, 32'd9, 8'hAA, 2'd3, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 8; i++) add_random(8);
        drain();

        // one symbol: fill the table, hit full, then sweep most of it in one order
        set_known(4'd1);
        for (int i = 0; i < ORDERS + 2; i++)
            add(CMD_NEW, 32'd1000 + i, 8'd0, SIDE_BUY, 16'(10 + (i % 3)), 16'd1);
        add(CMD_NEW, 32'd2000, 8'd1, SIDE_BUY, 16'd10, 16'd1);
        add(CMD_CANCEL, 32'd1000, 8'd0, 2'd0, 16'd0, 16'd0);
        add(CMD_NEW, 32'd2001, 8'd0, SIDE_SELL, 16'd1, 16'hFFFF);
        add(CMD_CANCEL, 32'd2001, 8'd0, 2'd0, 16'd0, 16'd0);
        for (int i = 0; i < 4; i++) add_random(1);
        drain();

        // above the build's symbol count: clamps to all symbols
        set_known(4'd15);
        for (int i = 0; i < 4; i++) add_random(8);
        drain();

        set_known(4'd3);
        for (int i = 0; i < 4; i++) add_random(4);
        drain();

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lobm_pkg.sv
hw/rtl/lobm_front.sv
hw/rtl/lobm_queue.sv
hw/rtl/lobm_back.sv
hw/rtl/limit_order_book_matcher_core.sv
test/limit_order_book_matcher_core_tb.sv
